### rtl/skpt_pkg.sv
package skpt_pkg;

    // Table geometry
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int KEY_W    = 64;
    localparam int PAY_W    = 64;
    localparam int ENTRY_W  = KEY_W + PAY_W;
    localparam int POS_W    = 9;
    localparam int COUNT_W  = 9;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [PAY_W-1:0]   t_pay;
    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [COUNT_W-1:0] t_count_out;

    typedef enum logic {
        REQ_SEARCH = 1'b0,
        REQ_INSERT = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DUP  = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

endpackage

### rtl/skpt_req_if.sv
interface skpt_req_if;
    import skpt_pkg::*;

    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_key      key;
    t_pay      payload;

    modport source (output valid, output req_type, output key, output payload, input ready);
    modport sink   (input valid, input req_type, input key, input payload, output ready);
endinterface

### rtl/skpt_rsp_if.sv
interface skpt_rsp_if;
    import skpt_pkg::*;

    logic       valid;
    logic       ready;
    t_status    status;
    t_pos       position;
    logic       found;
    t_count_out entry_count;

    modport source (output valid, output status, output position, output found,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input position, input found,
                    input entry_count, output ready);
endinterface

### rtl/skpt_ram.sv
module skpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### rtl/sorted_key_payload_table_insert_unit.sv
// Channel  | Dir | Handshake     | Transaction
// ---------+-----+---------------+------------------------------------------
// i_req    | in  | valid / ready | req_type, key, payload
// o_rsp    | out | valid / ready | status, position, found, entry_count
//
// One request at a time. A search or a rejected insert runs a binary search of at most 9
// probes, each a read and a compare on the entry RAM. A stored insert then shifts each
// entry from the insert point up one slot through the single read and write port,
// finishes the shift, and writes the new entry.
// Reset clears the entry count and control state; the entry RAM is not cleared.
// A request is taken while o_rsp holds a response; the next one waits in its last state.
module sorted_key_payload_table_insert_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skpt_req_if.sink   i_req,
    skpt_rsp_if.source o_rsp
);
    import skpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } t_state;

    // Control registers
    t_state     r_state, n_state;
    t_cnt       r_count, n_count;
    logic       r_rd_pend, n_rd_pend;
    logic       r_rsp_valid, n_rsp_valid;

    // Working registers
    t_req_type  r_req_type, n_req_type;
    t_key       r_key, n_key;
    t_pay       r_pay, n_pay;
    t_cnt       r_lo, n_lo;
    t_cnt       r_hi, n_hi;
    t_addr      r_mid, n_mid;
    logic       r_hit, n_hit;
    t_cnt       r_ptr, n_ptr;
    t_addr      r_wr_addr, n_wr_addr;
    t_status    r_status, n_status;

    // Response registers
    t_status    r_rsp_status, n_rsp_status;
    t_pos       r_rsp_pos, n_rsp_pos;
    logic       r_rsp_found, n_rsp_found;
    t_count_out r_rsp_count, n_rsp_count;

    // Entry RAM port
    logic       ram_rd_en;
    t_addr      ram_rd_addr;
    t_entry     ram_rd_data;
    logic       ram_wr_en;
    t_addr      ram_wr_addr;
    t_entry     ram_wr_data;

    t_cnt       mid_full;
    t_cnt       ptr_dec;
    t_key       rd_key;
    logic       rsp_free;

    skpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign mid_full = r_lo + ((r_hi - r_lo) >> 1);
    assign ptr_dec  = r_ptr - t_cnt'(1);
    assign rd_key   = ram_rd_data[ENTRY_W-1:PAY_W];
    assign rsp_free = !r_rsp_valid || o_rsp.ready;

    // Next-state and RAM access logic
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_pend    = r_rd_pend;
        n_rsp_valid  = r_rsp_valid;
        n_req_type   = r_req_type;
        n_key        = r_key;
        n_pay        = r_pay;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_hit        = r_hit;
        n_ptr        = r_ptr;
        n_wr_addr    = r_wr_addr;
        n_status     = r_status;
        n_rsp_status = r_rsp_status;
        n_rsp_pos    = r_rsp_pos;
        n_rsp_found  = r_rsp_found;
        n_rsp_count  = r_rsp_count;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = '0;
        ram_wr_data  = '0;

        // Drop the response once taken
        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req_type = i_req.req_type;
                    n_key      = i_req.key;
                    n_pay      = i_req.payload;
                    n_lo       = '0;
                    n_hi       = r_count;
                    n_hit      = 1'b0;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid_full[ADDR_W-1:0];
                    n_mid       = mid_full[ADDR_W-1:0];
                    n_state     = S_CMP;
                end else if (r_req_type == REQ_SEARCH) begin
                    n_status = STATUS_OK;
                    n_state  = S_DONE;
                end else if (r_hit) begin
                    n_status = STATUS_DUP;
                    n_state  = S_DONE;
                end else if (r_count >= t_cnt'(CAPACITY)) begin
                    n_status = STATUS_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_status  = STATUS_OK;
                    n_ptr     = r_count;
                    n_rd_pend = 1'b0;
                    n_state   = S_SHIFT;
                end
            end
            S_CMP: begin
                // Narrow the window; the last probe that moved hi decides the hit
                if (rd_key < r_key) begin
                    n_lo = t_cnt'(r_mid) + t_cnt'(1);
                end else begin
                    n_hi  = t_cnt'(r_mid);
                    n_hit = (rd_key == r_key);
                end
                n_state = S_PROBE;
            end
            S_SHIFT: begin
                // Write back the entry read last cycle one slot higher
                if (r_rd_pend) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_wr_addr;
                    ram_wr_data = ram_rd_data;
                end
                if (r_ptr > r_lo) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_dec[ADDR_W-1:0];
                    n_wr_addr   = r_ptr[ADDR_W-1:0];
                    n_ptr       = ptr_dec;
                    n_rd_pend   = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    n_state   = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_lo[ADDR_W-1:0];
                ram_wr_data = {r_key, r_pay};
                n_count     = r_count + t_cnt'(1);
                n_state     = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (rsp_free) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_status = r_status;
                    n_rsp_pos    = t_pos'(r_lo) + t_pos'(1);
                    n_rsp_found  = r_hit;
                    n_rsp_count  = t_count_out'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, datapath and response registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_rd_pend    <= n_rd_pend;
            r_rsp_valid  <= n_rsp_valid;
            r_req_type   <= n_req_type;
            r_key        <= n_key;
            r_pay        <= n_pay;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_mid        <= n_mid;
            r_hit        <= n_hit;
            r_ptr        <= n_ptr;
            r_wr_addr    <= n_wr_addr;
            r_status     <= n_status;
            r_rsp_status <= n_rsp_status;
            r_rsp_pos    <= n_rsp_pos;
            r_rsp_found  <= n_rsp_found;
            r_rsp_count  <= n_rsp_count;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_rsp_status;
    assign o_rsp.position    = r_rsp_pos;
    assign o_rsp.found       = r_rsp_found;
    assign o_rsp.entry_count = r_rsp_count;

    // Count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(CAPACITY))
        else $error("entry count above capacity");

    // Shift never writes the slot it reads in the same cycle
    a_shift_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("entry RAM read and write collide");

    // A present key is never reported as full
    a_found_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> (o_rsp.status != STATUS_FULL))
        else $error("found key reported as table full");

    // Storing the new entry bumps the count by one
    a_write_bumps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_count == $past(r_count) + t_cnt'(1)))
        else $error("count not advanced after insert");
endmodule
